/* sv/phc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phc_pkg
// shared types and constants of the ride height pid controller
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRV_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRV_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_HI   = 3'd7;

    // shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [2:0] MUL_SP = 3'd0;
    localparam logic [2:0] MUL_EP = 3'd1;
    localparam logic [2:0] MUL_KP = 3'd2;
    localparam logic [2:0] MUL_KD = 3'd3;
    localparam logic [2:0] MUL_US = 3'd4;
    localparam logic [2:0] MUL_KI = 3'd5;

    // shared divider
    localparam int DIV_W          = 56;
    localparam int DIVISOR_W      = 20;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_ITER       = DIV_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_ITER);

    localparam logic DIV_SEL_I = 1'b0;
    localparam logic DIV_SEL_D = 1'b1;

    localparam int US_PER_S = 1000000;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic        [30:0] ilim;
        logic signed [15:0] drv_hi;
        logic signed [15:0] drv_lo;
        logic signed [15:0] sp_lo;
        logic signed [15:0] sp_hi;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       err_en;
        logic       div_start;
        logic       div_sel;
        logic       p_en;
        logic       int_en;
        logic       acc_en;
        logic       fin_en;
        logic       zero_out;
    } cmd_t;

    typedef struct packed {
        logic period_zero;
        logic div_busy;
    } stat_t;

endpackage
`default_nettype wire

/* sv/phc_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phc_cfg_regs
// gain, limit and setpoint registers behind the configuration write port
// ----------------------------------------------------------------------------
module phc_cfg_regs import phc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp     <= 16'sd256;
            cfg_reg.ki     <= 16'sd0;
            cfg_reg.kd     <= 16'sd0;
            cfg_reg.ilim   <= 31'd655360;
            cfg_reg.drv_hi <= 16'sd3840;
            cfg_reg.drv_lo <= -16'sd3840;
            cfg_reg.sp_lo  <= 16'sd0;
            cfg_reg.sp_hi  <= 16'sd5120;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KP:     cfg_reg.kp     <= cfg_data[15:0];
                CFG_KI:     cfg_reg.ki     <= cfg_data[15:0];
                CFG_KD:     cfg_reg.kd     <= cfg_data[15:0];
                CFG_ILIM:   cfg_reg.ilim   <= cfg_data[30:0];
                CFG_DRV_HI: cfg_reg.drv_hi <= cfg_data[15:0];
                CFG_DRV_LO: cfg_reg.drv_lo <= cfg_data[15:0];
                CFG_SP_LO:  cfg_reg.sp_lo  <= cfg_data[15:0];
                CFG_SP_HI:  cfg_reg.sp_hi  <= cfg_data[15:0];
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/phc_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phc_divider
// iterative floor divider, signed dividend by positive divisor,
// several restoring steps per cycle
// ----------------------------------------------------------------------------
module phc_divider import phc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DIV_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]    divisor,
    output logic                         busy,
    output logic signed [DIV_W-1:0]      quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [DIV_W-1:0]     dq_reg;
    logic [DIV_W-1:0]     dq_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] d_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 qbit;

    assign busy = busy_reg;

    always_comb
    begin
        rem_next = rem_reg;
        dq_next  = dq_reg;
        trial    = '0;
        qbit     = 1'b0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial = {rem_next, dq_next[DIV_W-1]};
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, d_reg});
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                qbit     = 1'b0;
            end
            dq_next = {dq_next[DIV_W-2:0], qbit};
        end
    end

    // floor for negative dividends: -q - 1 when a remainder is left
    always_comb
    begin
        if (!neg_reg)
            quotient = dq_reg;
        else if (rem_reg != '0)
            quotient = ~dq_reg;
        else
            quotient = ~dq_reg + DIV_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_ITER - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIV_W-1];
            dq_reg  <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

endmodule
`default_nettype wire

/* sv/phc_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phc_datapath
// setpoint mapping, error, integral with clamp, derivative and drive clamp
// around one shared multiplier and one shared divider
// ----------------------------------------------------------------------------
module phc_datapath import phc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  wire logic signed [15:0] measured_height,
    input  wire logic signed [15:0] knob_position,
    input  wire logic [15:0]        period_us,
    output logic signed [15:0]      drive_angle
);

    logic signed [15:0]       height_reg;
    logic [15:0]              t_reg;
    logic [15:0]              t_next;
    logic [15:0]              period_reg;
    logic signed [15:0]       err_reg;
    logic signed [15:0]       err_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       p_reg;
    logic signed [57:0]       acc_reg;
    logic signed [57:0]       acc_next;
    logic signed [31:0]       integral_reg;
    logic signed [31:0]       integral_next;
    logic signed [15:0]       prev_err_reg;
    logic signed [15:0]       last_drive_reg;
    logic signed [15:0]       drive_reg;
    logic signed [15:0]       drive_next;

    logic signed [16:0]       knob_ext;
    logic signed [16:0]       knob_cl;
    logic signed [16:0]       t_sum;
    logic signed [16:0]       sp_diff;
    logic signed [16:0]       err_delta;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [18:0]       setpoint;
    logic signed [19:0]       err_wide;
    logic signed [DIV_W-1:0]  div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic                     div_busy;
    logic signed [DIV_W-1:0]  div_q;
    logic signed [56:0]       int_sum;
    logic signed [56:0]       int_lim;
    logic signed [57:0]       drv_sum;
    logic signed [49:0]       drv_wide;
    logic signed [49:0]       drv_hi_cl;
    logic signed [49:0]       drv_lo_cl;

    assign stat.period_zero = (period_us == 16'd0);
    assign stat.div_busy    = div_busy;
    assign drive_angle      = drive_reg;

    // knob saturated to -1..+1 and offset to 0..2
    always_comb
    begin
        knob_ext = {knob_position[15], knob_position};
        if (knob_ext < -17'sd16384)
            knob_cl = -17'sd16384;
        else if (knob_ext > 17'sd16384)
            knob_cl = 17'sd16384;
        else
            knob_cl = knob_ext;
        t_sum  = knob_cl + 17'sd16384;
        t_next = t_sum[15:0];
    end

    assign sp_diff   = {cfg.sp_hi[15], cfg.sp_hi} - {cfg.sp_lo[15], cfg.sp_lo};
    assign err_delta = {err_reg[15], err_reg} - {prev_err_reg[15], prev_err_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SP:
            begin
                mul_a = $signed({17'd0, t_reg});
                mul_b = MUL_W'(sp_diff);
            end
            MUL_EP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({17'd0, period_reg});
            end
            MUL_KP:
            begin
                mul_a = MUL_W'(cfg.kp);
                mul_b = MUL_W'(err_reg);
            end
            MUL_KD:
            begin
                mul_a = MUL_W'(cfg.kd);
                mul_b = MUL_W'(err_delta);
            end
            MUL_US:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(US_PER_S);
            end
            MUL_KI:
            begin
                mul_a = MUL_W'(cfg.ki);
                mul_b = MUL_W'(integral_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // setpoint and saturated error
    always_comb
    begin
        setpoint = 19'(cfg.sp_lo) + 19'($signed(prod_reg[32:15]));
        err_wide = 20'(setpoint) - 20'(height_reg);
        if (err_wide > 20'sd32767)
            err_next = 16'sd32767;
        else if (err_wide < -20'sd32768)
            err_next = -16'sd32768;
        else
            err_next = err_wide[15:0];
    end

    always_comb
    begin
        if (cmd.div_sel == DIV_SEL_I)
        begin
            div_dividend = $signed({prod_reg[DIV_W-9:0], 8'd0});
            div_divisor  = DIVISOR_W'(US_PER_S);
        end
        else
        begin
            div_dividend = prod_reg[DIV_W-1:0];
            div_divisor  = {{(DIVISOR_W-16){1'b0}}, period_reg};
        end
    end

    phc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // integral with symmetric clamp
    always_comb
    begin
        int_sum = 57'(integral_reg) + 57'(div_q);
        int_lim = $signed({26'd0, cfg.ilim});
        if (int_sum > int_lim)
            integral_next = int_lim[31:0];
        else if (int_sum < -int_lim)
            integral_next = 32'(-int_lim);
        else
            integral_next = int_sum[31:0];
    end

    assign acc_next = 58'(p_reg) + 58'($signed(prod_reg[47:8]));

    // final sum, upper clamp then lower clamp
    always_comb
    begin
        drv_sum  = acc_reg + 58'(div_q);
        drv_wide = drv_sum[57:8];
        if (drv_wide > 50'(cfg.drv_hi))
            drv_hi_cl = 50'(cfg.drv_hi);
        else
            drv_hi_cl = drv_wide;
        if (drv_hi_cl < 50'(cfg.drv_lo))
            drv_lo_cl = 50'(cfg.drv_lo);
        else
            drv_lo_cl = drv_hi_cl;
        drive_next = drv_lo_cl[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg   <= '0;
            prev_err_reg   <= '0;
            last_drive_reg <= '0;
        end
        else
        begin
            if (cmd.int_en)
                integral_reg <= integral_next;
            if (cmd.fin_en)
            begin
                prev_err_reg   <= err_reg;
                last_drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            height_reg <= measured_height;
            t_reg      <= t_next;
            period_reg <= period_us;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.err_en)
            err_reg <= err_next;
        if (cmd.p_en)
            p_reg <= prod_reg[31:0];
        if (cmd.acc_en)
            acc_reg <= acc_next;
        if (cmd.fin_en)
            drive_reg <= drive_next;
        else if (cmd.zero_out)
            drive_reg <= last_drive_reg;
    end

endmodule
`default_nettype wire

/* sv/phc_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phc_controller
// sequencer for one sample word and the result word handshake
// ----------------------------------------------------------------------------
module phc_controller import phc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic sample_valid,
    output logic      sample_stall,
    output logic      drive_valid,
    input  wire logic drive_stall,
    input  stat_t     stat,
    output cmd_t      cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ZERO   = 4'd1;
    localparam logic [3:0] S_MUL_SP = 4'd2;
    localparam logic [3:0] S_ERR    = 4'd3;
    localparam logic [3:0] S_MUL_EP = 4'd4;
    localparam logic [3:0] S_DIV_I  = 4'd5;
    localparam logic [3:0] S_MUL_D1 = 4'd6;
    localparam logic [3:0] S_MUL_D2 = 4'd7;
    localparam logic [3:0] S_WAIT_I = 4'd8;
    localparam logic [3:0] S_DIV_D  = 4'd9;
    localparam logic [3:0] S_SUM_I  = 4'd10;
    localparam logic [3:0] S_WAIT_D = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign drive_valid  = out_valid_reg;
    assign out_free     = !out_valid_reg || !drive_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && drive_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.period_zero ? S_ZERO : S_MUL_SP;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    cmd.zero_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MUL_SP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SP;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = S_MUL_EP;
            end
            S_MUL_EP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_EP;
                state_next  = S_DIV_I;
            end
            S_DIV_I:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_I;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_KP;
                state_next    = S_MUL_D1;
            end
            S_MUL_D1:
            begin
                cmd.p_en    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KD;
                state_next  = S_MUL_D2;
            end
            S_MUL_D2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_US;
                state_next  = S_WAIT_I;
            end
            S_WAIT_I:
            begin
                if (!stat.div_busy)
                begin
                    cmd.int_en = 1'b1;
                    state_next = S_DIV_D;
                end
            end
            S_DIV_D:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_D;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_KI;
                state_next    = S_SUM_I;
            end
            S_SUM_I:
            begin
                cmd.acc_en  = 1'b1;
                cmd.div_sel = DIV_SEL_D;
                state_next  = S_WAIT_D;
            end
            S_WAIT_D:
            begin
                cmd.div_sel = DIV_SEL_D;
                if (!stat.div_busy && out_free)
                begin
                    cmd.fin_en     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_zero_period_path: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stat.period_zero |=> state_reg == S_ZERO)
        else $error("zero period word did not take the repeat path");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    a_finish_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_en |-> !stat.div_busy && !(out_valid_reg && drive_stall))
        else $error("result written before divider done or over a held word");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == S_WAIT_D || $past(state_reg) == S_ZERO))
        else $error("result word raised outside a finishing state");

endmodule
`default_nettype wire

/* sv/pid_height_controller_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pid_height_controller_unit
// ride height pid controller: setpoint from knob, clamped integral,
// derivative over the sample period, clamped drive angle
// ----------------------------------------------------------------------------
// samples: a zero period word repeats the last drive, others run the full sequence
// sequencing: no new sample word is taken before the last result is written, paced
//   by the shared divider (4 quotient bits per cycle, used twice per sample)
// reset: asynchronous, clears integral, previous error and last drive,
//   loads register defaults; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module pid_height_controller_unit import phc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire logic signed [15:0]    measured_height,
    input  wire logic signed [15:0]    knob_position,
    input  wire logic [15:0]           period_us,
    output logic                       drive_valid,
    input  wire logic                  drive_stall,
    output logic signed [15:0]         drive_angle,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    phc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    phc_controller u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    phc_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .measured_height (measured_height),
        .knob_position   (knob_position),
        .period_us       (period_us),
        .drive_angle     (drive_angle)
    );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ride height pid controller: a directed table of
// samples under the reset registers, then random samples under several
// register settings, each drive word checked against a table value or an in-bench predictor
// ----------------------------------------------------------------------------
module testbench;
    import phc_pkg::*;

    localparam int N_DIRECTED      = 16;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_AT         = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic signed [15:0] height;
        logic signed [15:0] knob;
        logic        [15:0] period;
        logic               known;
        logic signed [15:0] drive;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    logic signed [15:0]    measured_height;
    logic signed [15:0]    knob_position;
    logic [15:0]           period_us;
    logic                  drive_valid;
    logic                  drive_stall;
    logic signed [15:0]    drive_angle;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t               reg_mirror;
    longint             integral_acc;
    longint             prev_error;
    logic signed [15:0] held_drive;
    logic signed [15:0] last_height;
    logic signed [15:0] expected_drive [$];
    int                 fail_count;
    bit                 no_idle;

    // reset registers: kp = 1.0, drive = clamp(error), setpoint 0..20 cm
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{0,      0,      0,     1, 0},
        '{0,      -16384, 1000,  1, 0},
        '{256,    -16384, 1000,  1, -256},
        '{-32768, 16384,  1000,  1, 3840},
        '{32767,  -16384, 1000,  1, -3840},
        '{5120,   32767,  500,   1, 0},
        '{100,    -32768, 500,   1, -100},
        '{0,      0,      0,     1, -100},
        '{0,      0,      65535, 1, 2560},
        '{1000,   0,      1,     1, 1560},
        '{-1,     -1,     65535, 1, 2560},
        '{32767,  16384,  0,     1, 2560},
        '{12345,  -12345, 777,   0, 0},
        '{-21846, 21845,  43690, 0, 0},
        '{21845,  -21846, 21845, 0, 0},
        '{-1,     16383,  3,     0, 0}
    };

    pid_height_controller_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .measured_height (measured_height),
        .knob_position   (knob_position),
        .period_us       (period_us),
        .drive_valid     (drive_valid),
        .drive_stall     (drive_stall),
        .drive_angle     (drive_angle),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v;
    endfunction

    function automatic logic signed [15:0] predict_drive(input logic signed [15:0] height,
                                                         input logic signed [15:0] knob,
                                                         input logic [15:0] period);
        longint knob_sat;
        longint per;
        longint setpoint;
        longint err;
        longint p_term;
        longint i_term;
        longint d_term;
        longint drv;
        if (period == 0)
            return held_drive;
        knob_sat = clip(longint'(knob), -16384, 16384);
        per = longint'(period);
        setpoint = longint'(reg_mirror.sp_lo)
                 + floor_div((knob_sat + 16384)
                             * (longint'(reg_mirror.sp_hi) - longint'(reg_mirror.sp_lo)), 32768);
        err = clip(setpoint - longint'(height), -32768, 32767);
        integral_acc = clip(integral_acc + floor_div(err * per * 256, US_PER_S),
                            -longint'(reg_mirror.ilim), longint'(reg_mirror.ilim));
        p_term = longint'(reg_mirror.kp) * err;
        i_term = floor_div(longint'(reg_mirror.ki) * integral_acc, 256);
        d_term = floor_div(longint'(reg_mirror.kd) * (err - prev_error) * US_PER_S, per);
        prev_error = err;
        drv = floor_div(p_term + i_term + d_term, 256);
        if (drv > longint'(reg_mirror.drv_hi))
            drv = longint'(reg_mirror.drv_hi);
        if (drv < longint'(reg_mirror.drv_lo))
            drv = longint'(reg_mirror.drv_lo);
        held_drive = drv[15:0];
        return held_drive;
    endfunction

    // unused upper data bits carry random filler
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] pad;
        pad = $urandom;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (idx == CFG_ILIM) ? {pad[31], val[30:0]} : {pad[31:16], val[15:0]};
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_KP:     reg_mirror.kp     = val[15:0];
            CFG_KI:     reg_mirror.ki     = val[15:0];
            CFG_KD:     reg_mirror.kd     = val[15:0];
            CFG_ILIM:   reg_mirror.ilim   = val[30:0];
            CFG_DRV_HI: reg_mirror.drv_hi = val[15:0];
            CFG_DRV_LO: reg_mirror.drv_lo = val[15:0];
            CFG_SP_LO:  reg_mirror.sp_lo  = val[15:0];
            CFG_SP_HI:  reg_mirror.sp_hi  = val[15:0];
            default:    ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] kp, input logic [31:0] ki,
                                  input logic [31:0] kd, input logic [31:0] ilim,
                                  input logic [31:0] drv_hi, input logic [31:0] drv_lo,
                                  input logic [31:0] sp_lo, input logic [31:0] sp_hi);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_ILIM, ilim);
        write_reg(CFG_DRV_HI, drv_hi);
        write_reg(CFG_DRV_LO, drv_lo);
        write_reg(CFG_SP_LO, sp_lo);
        write_reg(CFG_SP_HI, sp_hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_sample(input logic signed [15:0] height, input logic signed [15:0] knob,
                                input logic [15:0] period, input logic known,
                                input logic signed [15:0] known_drive);
        int                 gap;
        logic signed [15:0] want;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid    <= 1'b1;
        measured_height <= height;
        knob_position   <= knob;
        period_us       <= period;
        do @(posedge clk); while (sample_stall);
        want = predict_drive(height, knob, period);
        expected_drive.push_back(known ? known_drive : want);
    endtask

    task automatic run_random_samples(input int count);
        int                 pick;
        int                 mid;
        logic signed [15:0] height;
        logic signed [15:0] knob;
        logic [15:0]        period;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                period = 0;
            else if (pick < 18)
                period = $urandom;
            else if (pick < 30)
                period = $urandom_range(1, 20);
            else
                period = $urandom_range(200, 20000);
            pick = $urandom_range(0, 99);
            if (pick < 85)
                knob = $urandom_range(0, 32768) - 16384;
            else
                knob = $urandom;
            // height walks slowly half the time, else jumps near the middle of the setpoint range or anywhere
            pick = $urandom_range(0, 99);
            mid = (int'(reg_mirror.sp_lo) + int'(reg_mirror.sp_hi)) / 2;
            if (pick < 50)
                height = last_height + $urandom_range(0, 128) - 64;
            else if (pick < 80)
                height = mid + $urandom_range(0, 4096) - 2048;
            else
                height = $urandom;
            last_height = height;
            offer_sample(height, knob, period, 1'b0, 16'sd0);
        end
    endtask

    task automatic finish_phase();
        sample_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        reg_mirror.kp     = 16'sd256;
        reg_mirror.ki     = 16'sd0;
        reg_mirror.kd     = 16'sd0;
        reg_mirror.ilim   = 31'd655360;
        reg_mirror.drv_hi = 16'sd3840;
        reg_mirror.drv_lo = -16'sd3840;
        reg_mirror.sp_lo  = 16'sd0;
        reg_mirror.sp_hi  = 16'sd5120;
        integral_acc = 0;
        prev_error   = 0;
        held_drive   = 16'sd0;
        last_height  = 16'sd0;
        fail_count   = 0;
        no_idle      = 1'b0;

        rst_n           <= 1'b0;
        sample_valid    <= 1'b0;
        measured_height <= 16'sd0;
        knob_position   <= 16'sd0;
        period_us       <= 16'd0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_KP;
        cfg_data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            offer_sample(directed_rows[i].height, directed_rows[i].knob,
                         directed_rows[i].period, directed_rows[i].known,
                         directed_rows[i].drive);
        finish_phase();

        // typical gains, receiver hold-off lands here
        apply_settings(256, 64, 32, 655360, 3840, -3840, 0, 5120);
        run_random_samples(ITEMS_PER_PHASE);
        finish_phase();

        // largest values, no idling on either side
        no_idle = 1'b1;
        apply_settings(32767, 32767, 32767, 32'h7fff_ffff, 32767, -32768, -32768, 32767);
        run_random_samples(ITEMS_PER_PHASE);
        finish_phase();
        no_idle = 1'b0;

        // smallest values, crossed drive limits and downward setpoint range
        apply_settings(-32768, -32768, -32768, 0, -32768, 32767, 32767, -32768);
        run_random_samples(ITEMS_PER_PHASE);
        finish_phase();

        // fixed setpoint
        apply_settings(512, 300, -100, 20000, 2000, -2500, 1280, 1280);
        run_random_samples(ITEMS_PER_PHASE);
        finish_phase();

        apply_settings($urandom_range(0, 1024) - 512, $urandom_range(0, 256) - 128,
                       $urandom_range(0, 128) - 64, $urandom_range(0, 2000000),
                       $urandom_range(0, 8000), -$urandom_range(0, 8000),
                       $urandom_range(0, 6000) - 1000, $urandom_range(0, 6000) - 1000);
        run_random_samples(ITEMS_PER_PHASE);
        finish_phase();

        apply_settings($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        run_random_samples(ITEMS_PER_PHASE);
        finish_phase();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_drive.size() != 0)
        begin
            $error("drive_angle: %0d words never arrived", expected_drive.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : drive_sink
        logic signed [15:0] want;
        int                 received;
        int                 hold_left;
        int                 wait_left;
        received  = 0;
        hold_left = 0;
        wait_left = 0;
        drive_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && drive_valid && !drive_stall)
            begin
                received++;
                if (expected_drive.size() == 0)
                begin
                    $error("drive_angle: no word expected, got %0d", drive_angle);
                    fail_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (drive_angle !== want)
                    begin
                        $error("drive_angle: expected %0d, got %0d", want, drive_angle);
                        fail_count++;
                    end
                end
                if (received == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                else
                    wait_left = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                drive_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                drive_stall <= 1'b1;
            end
            else
                drive_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_valid && !sample_stall) || (drive_valid && !drive_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
